[hdl/hed_pkg.sv]
// Package for the character entity decoder: transaction types, entity table and limits.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package hed_pkg;

	localparam int ENT_COUNT   = 7;
	localparam int HOLD_MAX    = 5;
	localparam int MAX_RESULTS = 6;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] count_t;
	typedef logic [ENT_COUNT-1:0] ent_mask_t;

	localparam byte_t AMP = 8'h26;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} result_t;

	// Results released by one input transaction, entry zero first.
	typedef struct packed {
		count_t                       count;
		byte_t [MAX_RESULTS-1:0]      bytes;
		logic                         last;
	} emit_t;

	localparam byte_t ENT_TEXT [ENT_COUNT][MAX_RESULTS] = '{
		'{8'h26, 8'h23, 8'h78, 8'h32, 8'h62, 8'h3b},
		'{8'h26, 8'h23, 8'h78, 8'h33, 8'h64, 8'h3b},
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}
	};

	localparam count_t ENT_LEN [ENT_COUNT] = '{
		3'd6, 3'd6, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6
	};

	localparam byte_t ENT_VALUE [ENT_COUNT] = '{
		8'h2b, 8'h3d, 8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22
	};

endpackage

`default_nettype wire

[hdl/hed_decode.sv]
// Entity matcher: holds the bytes of a partial entity and decides what one transaction releases.
// Depends on hed_pkg for the entity table and the transaction types.
`default_nettype none

module hed_decode (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire hed_pkg::item_t item,
	output hed_pkg::emit_t      emit
);

	hed_pkg::byte_t     held_q [hed_pkg::HOLD_MAX];
	hed_pkg::count_t    cnt_q;
	hed_pkg::ent_mask_t alive_q;

	hed_pkg::ent_mask_t alive_next;
	hed_pkg::count_t    cnt_inc;
	hed_pkg::byte_t     full_value;
	hed_pkg::byte_t     b;
	logic               full_hit;
	logic               prefix_hit;
	logic               is_amp;
	logic               end_flag;
	logic [hed_pkg::HOLD_MAX-1:0] held_we;

	assign b        = item.in_byte;
	assign end_flag = item.end_of_text;
	assign is_amp   = (b == hed_pkg::AMP);
	assign cnt_inc  = hed_pkg::count_t'(cnt_q + 3'd1);

	always_comb begin
		alive_next = '0;
		full_hit   = 1'b0;
		prefix_hit = 1'b0;
		full_value = '0;
		for (int e = 0; e < hed_pkg::ENT_COUNT; e++) begin
			if (alive_q[e] && (hed_pkg::ENT_LEN[e] > cnt_q) &&
			    (hed_pkg::ENT_TEXT[e][cnt_q] == b)) begin
				alive_next[e] = 1'b1;
			end
		end
		for (int e = 0; e < hed_pkg::ENT_COUNT; e++) begin
			if (alive_next[e] && (hed_pkg::ENT_LEN[e] == cnt_inc)) begin
				full_hit   = 1'b1;
				full_value = hed_pkg::ENT_VALUE[e];
			end
			if (alive_next[e] && (hed_pkg::ENT_LEN[e] > cnt_inc)) begin
				prefix_hit = 1'b1;
			end
		end
	end

	// The released bytes are the held bytes followed by the new byte, unless a whole entity
	// was matched, a longer entity is still possible, or a new ampersand restarts the prefix.
	always_comb begin
		emit.last = end_flag;
		for (int k = 0; k < hed_pkg::HOLD_MAX; k++) begin
			emit.bytes[k] = (hed_pkg::count_t'(k) < cnt_q) ? held_q[k] : b;
		end
		emit.bytes[hed_pkg::MAX_RESULTS-1] = b;
		priority if (full_hit) begin
			emit.count    = 3'd1;
			emit.bytes[0] = full_value;
		end else if (end_flag) begin
			emit.count = cnt_inc;
		end else if (prefix_hit) begin
			emit.count = '0;
		end else begin
			emit.count = hed_pkg::count_t'(cnt_q + {2'b00, !is_amp});
		end
	end

	always_comb begin
		held_we = '0;
		if (step && !full_hit && !end_flag) begin
			if (prefix_hit) begin
				for (int k = 0; k < hed_pkg::HOLD_MAX; k++) begin
					held_we[k] = (hed_pkg::count_t'(k) == cnt_q);
				end
			end else if (is_amp) begin
				held_we[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < hed_pkg::HOLD_MAX; k++) begin
			if (held_we[k]) begin
				held_q[k] <= b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			alive_q <= '0;
		end else if (step) begin
			priority if (full_hit || end_flag) begin
				cnt_q   <= '0;
				alive_q <= '0;
			end else if (prefix_hit) begin
				cnt_q   <= cnt_inc;
				alive_q <= alive_next;
			end else if (is_amp) begin
				cnt_q   <= 3'd1;
				alive_q <= '1;
			end else begin
				cnt_q   <= '0;
				alive_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/hed_outbuf.sv]
// Result buffer: takes one transaction's bytes, sends them one per cycle unless stalled.
// Depends on hed_pkg for the emit and result types.
`default_nettype none

module hed_outbuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire hed_pkg::emit_t emit,
	output logic                can_load,
	output logic                result_valid,
	input  wire logic           result_stall,
	output hed_pkg::result_t    result
);

	hed_pkg::byte_t  buf_q [hed_pkg::MAX_RESULTS];
	hed_pkg::count_t cnt_q;
	logic            last_q;
	logic            take;

	assign result_valid    = (cnt_q != '0);
	assign take            = result_valid && !result_stall;
	assign can_load        = (cnt_q == '0) || ((cnt_q == 3'd1) && take);
	assign result.out_byte = buf_q[0];
	assign result.out_last = last_q && (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= emit.count;
			last_q <= emit.last;
		end else if (take) begin
			cnt_q  <= hed_pkg::count_t'(cnt_q - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < hed_pkg::MAX_RESULTS; k++) begin
				buf_q[k] <= emit.bytes[k];
			end
		end else if (take) begin
			for (int k = 0; k < hed_pkg::MAX_RESULTS - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

endmodule

`default_nettype wire

[hdl/html_entity_decoder_core.sv]
// Top level of the character entity decoder: input register, matcher and result buffer.
// Depends on hed_pkg, hed_decode and hed_outbuf.
//
// Usage: text bytes enter on the item channel (item_valid, item_stall, item), one byte per
// transaction, with end_of_text set on the final byte of a string. Decoded bytes leave on
// the result channel (result_valid, result_stall, result); out_last marks the final byte
// of a string. Seven entities are replaced by their single byte, everything else passes.
// A transaction passes through the input register and, when the result buffer is free,
// is loaded into the result buffer, which offers its first result.
// Throughput: one transaction per cycle while each one releases at most one result and
// the receiver does not stall. A transaction that releases n results (a mismatch or the
// end of a string flushes up to five held bytes plus the new one) holds the result channel
// until all n are taken, and the input register takes one more transaction meanwhile. The
// six-entry result buffer is reloaded only once its last entry is being taken.
// Reset clears the input register, the held entity prefix and the result buffer.
// While the receiver stalls, the current result holds and item_stall rises once the input
// register is occupied.
`default_nettype none

module html_entity_decoder_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire hed_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output hed_pkg::result_t      result
);

	logic             valid_s1;
	hed_pkg::item_t   item_s1;
	logic             can_load;
	logic             advance;
	hed_pkg::emit_t   emit;

	assign advance    = valid_s1 && can_load;
	assign item_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	hed_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.emit   (emit)
	);

	hed_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.emit         (emit),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("Input stalled while the result buffer is empty.");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.end_of_text) |=> result_valid)
		else $error("End of text produced no result.");

	a_last_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.end_of_text) |-> (emit.count != '0))
		else $error("End of text released an empty result set.");

endmodule

`default_nettype wire

[tb/sv/hed_stream_checker.sv]
// Stream checker for the character entity decoder: watches both channels, predicts the
// decoded bytes of every accepted transaction and compares them with the results.
// Depends on hed_pkg for the transaction types.
`timescale 1ns / 1ps
`default_nettype none

module hed_stream_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_stall,
	input  wire hed_pkg::item_t   item,
	input  wire logic             result_valid,
	input  wire logic             result_stall,
	input  wire hed_pkg::result_t result,
	output int                    failures,
	output int                    pending
);

	localparam int N_ENT = 7;
	localparam int HOLD_DEPTH = 5;
	localparam hed_pkg::byte_t AMPERSAND = 8'h26;

	string ent_text [N_ENT] = '{"&#x2b;", "&#x3d;", "&lt;", "&gt;", "&amp;", "&apos;",
		"&quot;"};
	hed_pkg::byte_t ent_value [N_ENT] = '{8'h2b, 8'h3d, 8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

	hed_pkg::byte_t held [HOLD_DEPTH];
	int held_n = 0;
	int fail_count = 0;
	int open_count = 0;
	hed_pkg::result_t expected_bytes [$];
	hed_pkg::result_t want;

	assign failures = fail_count;
	assign pending = open_count;

	task automatic push_byte(input hed_pkg::byte_t b);
		expected_bytes.push_back('{out_byte: b, out_last: 1'b0});
	endtask

	task automatic flush_held();
		for (int k = 0; k < held_n; k++)
			push_byte(held[k]);
		held_n = 0;
	endtask

	task automatic decode_byte(input hed_pkg::item_t it);
		hed_pkg::byte_t cand [HOLD_DEPTH + 1];
		int len;
		int full;
		int first;
		bit prefix;
		bit match;
		first = expected_bytes.size();
		if (held_n > 0) begin
			for (int k = 0; k < held_n; k++)
				cand[k] = held[k];
			cand[held_n] = it.in_byte;
			len = held_n + 1;
			full = -1;
			prefix = 1'b0;
			for (int e = 0; e < N_ENT; e++) begin
				if (ent_text[e].len() >= len) begin
					match = 1'b1;
					for (int k = 0; k < len; k++)
						if (hed_pkg::byte_t'(ent_text[e][k]) != cand[k])
							match = 1'b0;
					if (match && ent_text[e].len() == len)
						full = e;
					else if (match)
						prefix = 1'b1;
				end
			end
			if (full >= 0) begin
				held_n = 0;
				push_byte(ent_value[full]);
			end else if (prefix && len <= HOLD_DEPTH) begin
				held[held_n] = it.in_byte;
				held_n++;
			end else begin
				flush_held();
				if (it.in_byte == AMPERSAND) begin
					held[0] = it.in_byte;
					held_n = 1;
				end else begin
					push_byte(it.in_byte);
				end
			end
		end else if (it.in_byte == AMPERSAND) begin
			held[0] = it.in_byte;
			held_n = 1;
		end else begin
			push_byte(it.in_byte);
		end
		if (it.end_of_text) begin
			flush_held();
			if (expected_bytes.size() > first)
				expected_bytes[expected_bytes.size() - 1].out_last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes.delete();
			held_n = 0;
			open_count = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected result transaction: out_byte %h out_last %b",
						result.out_byte, result.out_last);
					fail_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, actual %h", want.out_byte,
							result.out_byte);
						fail_count++;
					end
					if (result.out_last !== want.out_last) begin
						$error("out_last: expected %b, actual %b", want.out_last,
							result.out_last);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				decode_byte(item);
			open_count = expected_bytes.size();
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_html_entity_decoder_core.sv]
// Testbench top for html_entity_decoder_core: clock, reset, byte stimulus with random idling
// and receiver stalls, and the final verdict. Depends on hed_pkg and hed_stream_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_html_entity_decoder_core;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	hed_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	hed_pkg::result_t result;
	int               failures;
	int               pending;

	string entity_list [7] = '{"&#x2b;", "&#x3d;", "&lt;", "&gt;", "&amp;", "&apos;",
		"&quot;"};
	int send_mode = 0;
	int sent = 0;
	int taken = 0;

	html_entity_decoder_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	hed_stream_checker stream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_html_entity_decoder_core NOT OK");
		$finish;
	end

	function automatic int draw_wait(input int mode);
		if (mode == 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	task automatic send_byte(input hed_pkg::byte_t b, input logic eot);
		int gap;
		gap = draw_wait(send_mode);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= '{in_byte: b, end_of_text: eot};
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		sent++;
		if (sent % 32 == 0)
			send_mode = $urandom_range(0, 2);
	endtask

	task automatic send_text(input string s, input bit eot_at_end);
		for (int k = 0; k < s.len(); k++)
			send_byte(s[k], eot_at_end && (k == s.len() - 1));
	endtask

	function automatic logic random_eot();
		return $urandom_range(0, 15) == 0;
	endfunction

	function automatic hed_pkg::byte_t random_text_byte();
		case ($urandom_range(0, 5))
			0: return 8'h26;
			1: return 8'h3b;
			2: return 8'h23;
			default: return hed_pkg::byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		string s;
		int ent;
		int cut;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_text("&lt;", 1'b0);
		send_text("&#x3d;", 1'b1);
		send_text("&&amp;", 1'b1);
		send_text("&apx", 1'b0);
		send_text("&x;", 1'b0);
		send_text("&quo", 1'b1);
		send_text("&", 1'b1);

		while (sent < 400) begin
			ent = $urandom_range(0, 6);
			s = entity_list[ent];
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					for (int k = 0; k < s.len(); k++)
						send_byte(s[k], random_eot());
				end
				5, 6: begin
					cut = $urandom_range(1, s.len() - 1);
					for (int k = 0; k < cut; k++)
						send_byte(s[k], random_eot());
					send_byte(random_text_byte(), random_eot());
				end
				7: begin
					s[$urandom_range(1, s.len() - 1)] = random_text_byte();
					for (int k = 0; k < s.len(); k++)
						send_byte(s[k], random_eot());
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send_byte(random_text_byte(), random_eot());
				end
			endcase
		end
		item_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("tb_html_entity_decoder_core OK");
		else
			$display("tb_html_entity_decoder_core NOT OK");
		$finish;
	end

	initial begin
		int hold;
		int recv_mode;
		recv_mode = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (taken == 60)
				hold = 200;
			else
				hold = draw_wait(recv_mode);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
			taken++;
			if (taken % 32 == 0)
				recv_mode = $urandom_range(0, 2);
		end
	end

endmodule

`default_nettype wire
